// ===== rtl/core/xmodem_block_receiver_top_defines.svh =====
// assertion macros shared by the receiver rtl
`ifndef XMODEM_BLOCK_RECEIVER_TOP_DEFINES_SVH
`define XMODEM_BLOCK_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define XMBR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xmbr assertion failed");

// next-cycle implication, disabled during reset
`define XMBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xmbr assertion failed");

`endif

// ===== rtl/core/xmbr_pkg.sv =====
// shared types and constants of the xmodem receiver
package xmbr_pkg;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;

   localparam logic [7:0] FRAME_LEN = 8'd131;
   localparam logic [7:0] SUM_POS   = 8'd130;

   localparam logic [7:0] RETRY_LIMIT_RESET = 8'd10;
   localparam logic [7:0] RETRY_MAX         = 8'hFF;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_REPLY   = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      LINK_RECEIVING = 2'd0,
      LINK_FINISHED  = 2'd1,
      LINK_ABORTED   = 2'd2
   } status_type;

endpackage

// ===== rtl/core/xmbr_if.sv =====
// channel interfaces of the xmodem receiver

interface xmbr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface xmbr_rsp_if;
   logic                   valid;
   logic                   ready;
   xmbr_pkg::kind_type     kind;
   logic [7:0]             data_byte;
   logic [6:0]             payload_index;
   logic                   commit;
   xmbr_pkg::status_type   link_status;

   modport source (output valid, output kind, output data_byte, output payload_index,
                   output commit, output link_status, input ready);
   modport sink   (input valid, input kind, input data_byte, input payload_index,
                   input commit, input link_status, output ready);
endinterface

interface xmbr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] retry_limit;

   modport source (output valid, output retry_limit, input ready);
   modport sink   (input valid, input retry_limit, output ready);
endinterface

// ===== rtl/core/xmodem_block_receiver_top.sv =====
// xmodem checksum receiver: takes received bytes and timeouts, gives payload and replies
//
// receiving side of xmodem with an 8-bit checksum. each req transfer carries one
// received byte (op 0) or a reply timeout event (op 1). payload bytes of a frame come
// out on rsp as kind payload with their index 0..127; the checksum byte of a frame
// produces the reply (ack, nak or cancel) with commit set only when the frame is new
// and good. an eot header is acked and ends the link, a cancel header, a timeout or a
// header seen at the retry limit aborts it; after that all input is swallowed with
// no response. header bytes other than soh/eot/cancel make the block skip 131 bytes
// and nak. throughput is one byte per clock: the byte sits in an input register, one
// pass of the frame state logic decides the response, and the response is held in an
// output register. req stalls only while the output register is full and not being
// taken. retry_limit (reset 10) is written on the csr channel, which is always ready;
// write it only while the link is idle. reset is synchronous; there is no clearing
// pass after reset.
`include "xmodem_block_receiver_top_defines.svh"

module xmodem_block_receiver_top (
   input logic          clock,
   input logic          reset,
   xmbr_req_if.sink     req_chan,
   xmbr_rsp_if.source   rsp_chan,
   xmbr_csr_if.sink     csr_chan
);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_FRAME  = 3'd1,
      PH_SKIP   = 3'd2,
      PH_DONE   = 3'd3,
      PH_ABORT  = 3'd4
   } phase_type;

   // configuration
   logic [7:0] retry_limit_ff;

   // input register
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;

   // protocol state
   phase_type  phase_ff, phase_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] sequence_ff, sequence_in;
   logic [7:0] retry_ff, retry_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] number_ff, number_in;
   logic [7:0] complement_ff, complement_in;

   // output register
   logic                 out_valid_ff;
   xmbr_pkg::kind_type   out_kind_ff;
   logic [7:0]           out_data_ff;
   logic [6:0]           out_index_ff;
   logic                 out_commit_ff;
   xmbr_pkg::status_type out_status_ff;

   // response of the current pass
   logic                 res_valid;
   xmbr_pkg::kind_type   res_kind;
   logic [7:0]           res_data;
   logic [6:0]           res_index;
   logic                 res_commit;
   xmbr_pkg::status_type res_status;

   logic       out_free;
   logic       proc_go;
   logic       req_fire;
   logic [7:0] retry_bump;
   logic [7:0] pos_next;
   logic [7:0] pos_minus2;
   logic [7:0] seq_prev;
   logic [7:0] header_code;

   // output slot can take a new response when empty or being drained
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign proc_go  = in_valid_ff && out_free;

   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign retry_bump  = (retry_ff == xmbr_pkg::RETRY_MAX) ? retry_ff : retry_ff + 8'd1;
   assign pos_next    = position_ff + 8'd1;
   assign pos_minus2  = position_ff - 8'd2;
   assign seq_prev    = sequence_ff - 8'd1;
   // header bytes are matched with bit 7 ignored
   assign header_code = {1'b0, in_byte_ff[6:0]};

   always_comb begin
      phase_in      = phase_ff;
      position_in   = position_ff;
      sequence_in   = sequence_ff;
      retry_in      = retry_ff;
      sum_in        = sum_ff;
      number_in     = number_ff;
      complement_in = complement_ff;
      res_valid     = 1'b0;
      res_kind      = xmbr_pkg::KIND_PAYLOAD;
      res_data      = 8'd0;
      res_index     = 7'd0;
      res_commit    = 1'b0;

      if (proc_go && (phase_ff == PH_HEADER || phase_ff == PH_FRAME
                      || phase_ff == PH_SKIP)) begin
         if (in_op_ff) begin
            // timeout while receiving: cancel the link
            phase_in  = PH_ABORT;
            res_valid = 1'b1;
            res_kind  = xmbr_pkg::KIND_REPLY;
            res_data  = xmbr_pkg::CH_CAN;
         end else begin
            case (phase_ff)
               PH_SKIP: begin
                  position_in = pos_next;
                  if (pos_next >= xmbr_pkg::FRAME_LEN) begin
                     position_in = 8'd0;
                     phase_in    = PH_HEADER;
                     retry_in    = retry_bump;
                     res_valid   = 1'b1;
                     res_kind    = xmbr_pkg::KIND_REPLY;
                     res_data    = xmbr_pkg::CH_NAK;
                  end
               end
               PH_FRAME: begin
                  position_in = pos_next;
                  if (position_ff == 8'd0) begin
                     number_in = in_byte_ff;
                  end else if (position_ff == 8'd1) begin
                     complement_in = in_byte_ff;
                  end else if (position_ff < xmbr_pkg::SUM_POS) begin
                     sum_in    = sum_ff + in_byte_ff;
                     res_valid = 1'b1;
                     res_kind  = xmbr_pkg::KIND_PAYLOAD;
                     res_data  = in_byte_ff;
                     res_index = pos_minus2[6:0];
                  end else begin
                     // checksum byte: decide the reply for the frame
                     position_in = 8'd0;
                     phase_in    = PH_HEADER;
                     res_valid   = 1'b1;
                     res_kind    = xmbr_pkg::KIND_REPLY;
                     if (number_ff != sequence_ff) begin
                        if (number_ff != seq_prev && complement_ff != ~sequence_ff) begin
                           if (complement_ff == ~seq_prev) begin
                              retry_in = retry_bump;
                              res_data = xmbr_pkg::CH_NAK;
                           end else begin
                              phase_in = PH_ABORT;
                              res_data = xmbr_pkg::CH_CAN;
                           end
                        end else begin
                           // duplicate frame: ack without keeping it
                           retry_in = retry_bump;
                           res_data = xmbr_pkg::CH_ACK;
                        end
                     end else if (complement_ff != ~sequence_ff || in_byte_ff != sum_ff) begin
                        retry_in = retry_bump;
                        res_data = xmbr_pkg::CH_NAK;
                     end else begin
                        retry_in    = 8'd0;
                        sequence_in = sequence_ff + 8'd1;
                        res_data    = xmbr_pkg::CH_ACK;
                        res_commit  = 1'b1;
                     end
                  end
               end
               PH_HEADER: begin
                  if (retry_ff >= retry_limit_ff) begin
                     phase_in  = PH_ABORT;
                     res_valid = 1'b1;
                     res_kind  = xmbr_pkg::KIND_REPLY;
                     res_data  = xmbr_pkg::CH_CAN;
                  end else if (header_code == xmbr_pkg::CH_SOH) begin
                     phase_in    = PH_FRAME;
                     position_in = 8'd0;
                     sum_in      = 8'd0;
                  end else if (header_code == xmbr_pkg::CH_CAN) begin
                     phase_in  = PH_ABORT;
                     res_valid = 1'b1;
                     res_kind  = xmbr_pkg::KIND_STATUS;
                  end else if (header_code == xmbr_pkg::CH_EOT) begin
                     phase_in  = PH_DONE;
                     res_valid = 1'b1;
                     res_kind  = xmbr_pkg::KIND_REPLY;
                     res_data  = xmbr_pkg::CH_ACK;
                  end else begin
                     // unknown header: skip a frame's worth of bytes
                     phase_in    = PH_SKIP;
                     position_in = 8'd0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // link status reflects the phase after this byte
   always_comb begin
      case (phase_in)
         PH_DONE:  res_status = xmbr_pkg::LINK_FINISHED;
         PH_ABORT: res_status = xmbr_pkg::LINK_ABORTED;
         default:  res_status = xmbr_pkg::LINK_RECEIVING;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= xmbr_pkg::RETRY_LIMIT_RESET;
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_HEADER;
         position_ff    <= 8'd0;
         sequence_ff    <= 8'd1;
         retry_ff       <= 8'd0;
         sum_ff         <= 8'd0;
         number_ff      <= 8'd0;
         complement_ff  <= 8'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            retry_limit_ff <= csr_chan.retry_limit;
         end
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (proc_go) begin
            in_valid_ff <= 1'b0;
         end
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         sequence_ff   <= sequence_in;
         retry_ff      <= retry_in;
         sum_ff        <= sum_in;
         number_ff     <= number_in;
         complement_ff <= complement_in;
         if (out_free) begin
            out_valid_ff <= res_valid;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff   <= req_chan.op;
         in_byte_ff <= req_chan.rx_byte;
      end
      if (out_free && res_valid) begin
         out_kind_ff   <= res_kind;
         out_data_ff   <= res_data;
         out_index_ff  <= res_index;
         out_commit_ff <= res_commit;
         out_status_ff <= res_status;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_kind_ff;
   assign rsp_chan.data_byte     = out_data_ff;
   assign rsp_chan.payload_index = out_index_ff;
   assign rsp_chan.commit        = out_commit_ff;
   assign rsp_chan.link_status   = out_status_ff;

   // a finished link stays finished
   `XMBR_ASSERT_NEXT(a_done_sticky, clock, reset, phase_ff == PH_DONE, phase_ff == PH_DONE)
   // an aborted link stays aborted
   `XMBR_ASSERT_NEXT(a_abort_sticky, clock, reset, phase_ff == PH_ABORT,
                     phase_ff == PH_ABORT)
   // sequence number only advances together with a committing ack
   `XMBR_ASSERT_NEXT(a_seq_on_commit, clock, reset, !(res_valid && res_commit),
                     $stable(sequence_ff))
   // a commit only ever rides on an ack reply
   `XMBR_ASSERT_NOW(a_commit_is_ack, clock, reset, out_valid_ff && out_commit_ff,
                    out_kind_ff == xmbr_pkg::KIND_REPLY && out_data_ff == xmbr_pkg::CH_ACK)
   // between frames the byte position is back at zero
   `XMBR_ASSERT_NOW(a_header_pos, clock, reset, phase_ff == PH_HEADER, position_ff == 8'd0)

endmodule
